@@ sv/edf_pkg.sv @@
`timescale 1ns / 1ps

package edf_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_DEQ  = 2'd1;
  localparam logic [1:0] CMD_PICK = 2'd2;
  localparam logic [1:0] CMD_TICK = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_RUN_MISS = 3'd3;
  localparam logic [2:0] ST_Q_MISS   = 3'd4;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] dl;
    logic        unf;
  } slot_t;

endpackage

@@ sv/edf_deadline_scheduler.sv @@
`timescale 1ns / 1ps
// Enqueue, and pick/dequeue/tick on an empty queue: word out the cycle after accept.
// Pick and tick walk all queued entries through one memory read port; dequeue
// then adds a shift pass that moves each entry above the removed slot down one.
// One word in flight at a time; in_ready drops until the result is taken.
// Synchronous reset empties the queue and clears control; slot memory is not cleared.
module edf_deadline_scheduler import edf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       cmd,
  input  logic [7:0]       proc_id,
  input  logic             is_rt,
  input  logic [15:0]      deadline,
  input  logic [15:0]      run_count,
  input  logic [15:0]      job_len,
  input  logic [15:0]      period_len,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       picked_id,
  output logic [15:0]      new_deadline,
  output logic [15:0]      new_run_count,
  output logic             resched,
  output logic [2:0]       status,
  output logic [CNT_W-1:0] queue_count
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  slot_t             mem [QUEUE_DEPTH];
  slot_t             rd_data;
  logic [1:0]        state;
  logic [1:0]        op;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  iss;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_idx;
  logic [15:0]       best_dl;
  logic [IDX_W-1:0]  best_idx;
  logic [7:0]        best_id;
  logic              qmiss;
  logic [15:0]       t_nd;
  logic [15:0]       t_nc;
  logic              t_rs;
  logic              t_rmiss;

  logic              accept;
  logic              re;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  slot_t             wdata;
  logic [15:0]       aged;
  logic              aged_miss;
  logic [15:0]       cmp_val;
  logic [15:0]       nd1;
  logic [15:0]       nc1;
  logic              rmiss1;
  logic [16:0]       sum;
  logic [15:0]       tk_nd;
  logic [15:0]       tk_nc;
  logic              tk_rs;
  logic              tk_rmiss;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign accept   = in_valid && in_ready;
  assign re       = ((state == S_SCAN) || (state == S_SHIFT)) && (iss < count);

  // age one queued deadline
  always_comb begin
    aged      = (rd_data.dl == 16'd0) ? 16'd0 : rd_data.dl - 16'd1;
    aged_miss = (rd_data.dl == 16'd0) || ((aged == 16'd0) && rd_data.unf);
    cmp_val   = (op == CMD_TICK) ? aged : rd_data.dl;
  end

  // running task update
  always_comb begin
    nd1    = deadline;
    nc1    = run_count;
    rmiss1 = 1'b0;
    tk_rs  = !is_rt;
    if (is_rt && (run_count < job_len)) begin
      nc1 = run_count + 16'd1;
      if (deadline == 16'd0) begin
        rmiss1 = 1'b1;
      end else begin
        nd1 = deadline - 16'd1;
      end
    end
    if (is_rt && (nd1 == 16'd0) && (nc1 < job_len)) begin
      rmiss1 = 1'b1;
    end
    sum   = {1'b0, nd1} + {1'b0, period_len};
    tk_nd = nd1;
    tk_nc = nc1;
    if (is_rt && (nc1 == job_len)) begin
      tk_rs = 1'b1;
      tk_nc = 16'd0;
      tk_nd = sum[16] ? 16'hFFFF : sum[15:0];
    end
    tk_rmiss = rmiss1;
  end

  always_comb begin
    we    = 1'b0;
    waddr = count[IDX_W-1:0];
    wdata = '{id: proc_id, dl: deadline, unf: (run_count < job_len)};
    if (accept && (cmd == CMD_ENQ) && (count < CNT_W'(QUEUE_DEPTH))) begin
      we = 1'b1;
    end else if ((state == S_SCAN) && rd_vld && (op == CMD_TICK)) begin
      we    = 1'b1;
      waddr = rd_idx;
      wdata = '{id: rd_data.id, dl: aged, unf: rd_data.unf};
    end else if ((state == S_SHIFT) && rd_vld) begin
      we    = 1'b1;
      waddr = rd_idx - IDX_W'(1);
      wdata = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[iss[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op            <= cmd;
            picked_id     <= 8'd0;
            new_deadline  <= 16'd0;
            new_run_count <= 16'd0;
            resched       <= 1'b0;
            status        <= ST_OK;
            queue_count   <= count;
            iss           <= '0;
            qmiss         <= 1'b0;
            t_nd          <= tk_nd;
            t_nc          <= tk_nc;
            t_rs          <= tk_rs;
            t_rmiss       <= tk_rmiss;
            unique case (cmd)
              CMD_ENQ: begin
                out_valid <= 1'b1;
                if (count < CNT_W'(QUEUE_DEPTH)) begin
                  count       <= count + CNT_W'(1);
                  queue_count <= count + CNT_W'(1);
                end else begin
                  status <= ST_FULL;
                end
              end
              CMD_DEQ, CMD_PICK: begin
                if (count == '0) begin
                  status    <= ST_EMPTY;
                  out_valid <= 1'b1;
                end else begin
                  state <= S_SCAN;
                end
              end
              CMD_TICK: begin
                if (count == '0) begin
                  new_deadline  <= tk_nd;
                  new_run_count <= tk_nc;
                  resched       <= tk_rs;
                  status        <= tk_rmiss ? ST_RUN_MISS : ST_OK;
                  out_valid     <= 1'b1;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (re) begin
            iss <= iss + CNT_W'(1);
          end
          rd_vld <= re;
          rd_idx <= iss[IDX_W-1:0];
          if (rd_vld) begin
            if ((rd_idx == '0) || (cmp_val < best_dl)) begin
              best_dl  <= cmp_val;
              best_idx <= rd_idx;
              best_id  <= rd_data.id;
            end
            if ((op == CMD_TICK) && aged_miss) begin
              qmiss <= 1'b1;
            end
          end
          if (!re && !rd_vld) begin
            if (op == CMD_TICK) begin
              new_deadline  <= t_nd;
              new_run_count <= t_nc;
              resched       <= t_rs || (best_dl < t_nd);
              status        <= t_rmiss ? ST_RUN_MISS : (qmiss ? ST_Q_MISS : ST_OK);
              out_valid     <= 1'b1;
              state         <= S_IDLE;
            end else if (op == CMD_PICK) begin
              picked_id <= best_id;
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end else begin
              // close the gap above the removed slot
              iss   <= CNT_W'(best_idx) + CNT_W'(1);
              state <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          if (re) begin
            iss <= iss + CNT_W'(1);
          end
          rd_vld <= re;
          rd_idx <= iss[IDX_W-1:0];
          if (!re && !rd_vld) begin
            count       <= count - CNT_W'(1);
            queue_count <= count - CNT_W'(1);
            picked_id   <= best_id;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
